// ===== design/s5hp_pkg.sv =====
// s5hp_pkg: shared types and codes for the socks5 handshake parser
// no dependencies; imported by every module of the block
`default_nettype none

package s5hp_pkg;

    // input commands
    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_CLOSE = 2'd1;
    localparam logic [1:0] CMD_NEW   = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_REPLY = 2'd0;
    localparam logic [1:0] KIND_ADDR  = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    // address type codes on the result side
    localparam logic [1:0] AT_IPV4   = 2'd0;
    localparam logic [1:0] AT_DOMAIN = 2'd1;
    localparam logic [1:0] AT_IPV6   = 2'd2;

    // protocol bytes
    localparam logic [7:0] SOCKS_VER      = 8'h05;
    localparam logic [7:0] METHOD_NOAUTH  = 8'h00;
    localparam logic [7:0] METHOD_NONE    = 8'hFF;
    localparam logic [7:0] REQ_CONNECT    = 8'h01;
    localparam logic [7:0] REQ_RSV        = 8'h00;
    localparam logic [7:0] ATYP_IPV4      = 8'h01;
    localparam logic [7:0] ATYP_DOMAIN    = 8'h03;
    localparam logic [7:0] ATYP_IPV6      = 8'h04;
    localparam logic [7:0] REP_GENERAL    = 8'h01;
    localparam logic [7:0] REP_CMD_UNSUP  = 8'h07;
    localparam logic [7:0] REP_ATYP_UNSUP = 8'h08;

    localparam logic [7:0] IPV4_LEN = 8'd4;
    localparam logic [7:0] IPV6_LEN = 8'd16;

    // error reply is 05 REP 00 01 and six zero bytes
    localparam int FAIL_LEN = 10;
    localparam int IDX_W    = $clog2(FAIL_LEN);

    // default depth of the action queue
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  value;
        logic [1:0]  addr_type;
        logic [15:0] dest_port;
        logic        close_after;
        logic        last;
    } out_item_t;

    // what the front asks the back to emit
    typedef enum logic [2:0] {
        ACT_FAIL,
        ACT_HELLO_OK,
        ACT_HELLO_REJ,
        ACT_ADDR,
        ACT_DONE
    } act_op_t;

    typedef struct packed {
        act_op_t     op;
        logic [7:0]  data;
        logic [1:0]  addr_type;
        logic [15:0] dest_port;
    } action_t;

endpackage

`default_nettype wire

// ===== design/s5hp_front.sv =====
// s5hp_front: byte parser for greeting and request, one action per byte at most
// depends on s5hp_pkg
`default_nettype none

module s5hp_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire s5hp_pkg::in_item_t s_item,
    input  wire logic              act_ready,
    output logic                   act_valid,
    output s5hp_pkg::action_t      act
);
    import s5hp_pkg::*;

    typedef enum logic [3:0] {
        PH_GREET_VER,
        PH_GREET_NM,
        PH_METHODS,
        PH_REQ_VER,
        PH_REQ_CMD,
        PH_REQ_RSV,
        PH_REQ_ATYP,
        PH_DOM_LEN,
        PH_ADDR,
        PH_PORT_HI,
        PH_PORT_LO,
        PH_CLOSED
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic       ver_ok_reg, ver_ok_next;
    logic [7:0] methods_left_reg, methods_left_next;
    logic       noauth_reg, noauth_next;
    logic [3:0] fault_reg, fault_next;
    logic [1:0] addr_kind_reg, addr_kind_next;
    logic [7:0] addr_left_reg, addr_left_next;
    logic [7:0] port_hi_reg, port_hi_next;

    logic       accept;
    logic [7:0] b;
    logic [7:0] methods_dec;
    logic [7:0] addr_dec;

    assign s_ready     = act_ready;
    assign accept      = s_valid && s_ready;
    assign b           = s_item.rx_byte;
    assign methods_dec = methods_left_reg - 8'd1;
    assign addr_dec    = addr_left_reg - 8'd1;

    // parse one input item (byte, close or new connection) and decide the action
    always_comb begin
        phase_next        = phase_reg;
        ver_ok_next       = ver_ok_reg;
        methods_left_next = methods_left_reg;
        noauth_next       = noauth_reg;
        fault_next        = fault_reg;
        addr_kind_next    = addr_kind_reg;
        addr_left_next    = addr_left_reg;
        port_hi_next      = port_hi_reg;
        act_valid         = 1'b0;
        act.op            = ACT_FAIL;
        act.data          = REP_GENERAL;
        act.addr_type     = addr_kind_reg;
        act.dest_port     = {port_hi_reg, b};

        if (accept) begin
            case (s_item.cmd)
                CMD_NEW: begin
                    phase_next        = PH_GREET_VER;
                    ver_ok_next       = 1'b0;
                    methods_left_next = '0;
                    noauth_next       = 1'b0;
                    fault_next        = '0;
                    addr_kind_next    = AT_IPV4;
                    addr_left_next    = '0;
                    port_hi_next      = '0;
                end
                CMD_CLOSE: begin
                    if (phase_reg != PH_CLOSED) begin
                        act_valid  = 1'b1;
                        phase_next = PH_CLOSED;
                    end
                end
                CMD_BYTE: begin
                    case (phase_reg)
                        PH_GREET_VER: begin
                            ver_ok_next = (b == SOCKS_VER);
                            phase_next  = PH_GREET_NM;
                        end
                        PH_GREET_NM: begin
                            if (!ver_ok_reg || b == 8'd0) begin
                                act_valid  = 1'b1;
                                phase_next = PH_CLOSED;
                            end else begin
                                methods_left_next = b;
                                noauth_next       = 1'b0;
                                phase_next        = PH_METHODS;
                            end
                        end
                        PH_METHODS: begin
                            methods_left_next = methods_dec;
                            if (b == METHOD_NOAUTH) begin
                                noauth_next = 1'b1;
                            end
                            if (methods_dec == 8'd0) begin
                                act_valid = 1'b1;
                                if (noauth_reg || b == METHOD_NOAUTH) begin
                                    act.op     = ACT_HELLO_OK;
                                    phase_next = PH_REQ_VER;
                                end else begin
                                    act.op     = ACT_HELLO_REJ;
                                    phase_next = PH_CLOSED;
                                end
                            end
                        end
                        PH_REQ_VER: begin
                            fault_next = (b != SOCKS_VER) ? REP_GENERAL[3:0] : 4'd0;
                            phase_next = PH_REQ_CMD;
                        end
                        PH_REQ_CMD: begin
                            if (fault_reg == 4'd0 && b != REQ_CONNECT) begin
                                fault_next = REP_CMD_UNSUP[3:0];
                            end
                            phase_next = PH_REQ_RSV;
                        end
                        PH_REQ_RSV: begin
                            if (fault_reg == 4'd0 && b != REQ_RSV) begin
                                fault_next = REP_GENERAL[3:0];
                            end
                            phase_next = PH_REQ_ATYP;
                        end
                        PH_REQ_ATYP: begin
                            if (fault_reg != 4'd0) begin
                                act_valid  = 1'b1;
                                act.data   = {4'd0, fault_reg};
                                phase_next = PH_CLOSED;
                            end else if (b == ATYP_IPV4) begin
                                addr_kind_next = AT_IPV4;
                                addr_left_next = IPV4_LEN;
                                phase_next     = PH_ADDR;
                            end else if (b == ATYP_IPV6) begin
                                addr_kind_next = AT_IPV6;
                                addr_left_next = IPV6_LEN;
                                phase_next     = PH_ADDR;
                            end else if (b == ATYP_DOMAIN) begin
                                addr_kind_next = AT_DOMAIN;
                                phase_next     = PH_DOM_LEN;
                            end else begin
                                act_valid  = 1'b1;
                                act.data   = REP_ATYP_UNSUP;
                                phase_next = PH_CLOSED;
                            end
                        end
                        PH_DOM_LEN: begin
                            addr_left_next = b;
                            phase_next     = (b == 8'd0) ? PH_PORT_HI : PH_ADDR;
                        end
                        PH_ADDR: begin
                            act_valid      = 1'b1;
                            act.op         = ACT_ADDR;
                            act.data       = b;
                            addr_left_next = addr_dec;
                            if (addr_dec == 8'd0) begin
                                phase_next = PH_PORT_HI;
                            end
                        end
                        PH_PORT_HI: begin
                            port_hi_next = b;
                            phase_next   = PH_PORT_LO;
                        end
                        PH_PORT_LO: begin
                            act_valid  = 1'b1;
                            act.op     = ACT_DONE;
                            act.data   = 8'd0;
                            phase_next = PH_REQ_VER;
                        end
                        default: begin
                            // closed: bytes are dropped
                        end
                    endcase
                end
                default: begin
                    // unused command code
                end
            endcase
        end
    end

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_GREET_VER;
            ver_ok_reg       <= 1'b0;
            methods_left_reg <= '0;
            noauth_reg       <= 1'b0;
            fault_reg        <= '0;
            addr_kind_reg    <= AT_IPV4;
            addr_left_reg    <= '0;
            port_hi_reg      <= '0;
        end else begin
            phase_reg        <= phase_next;
            ver_ok_reg       <= ver_ok_next;
            methods_left_reg <= methods_left_next;
            noauth_reg       <= noauth_next;
            fault_reg        <= fault_next;
            addr_kind_reg    <= addr_kind_next;
            addr_left_reg    <= addr_left_next;
            port_hi_reg      <= port_hi_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/s5hp_queue.sv =====
// s5hp_queue: small fifo of actions between parser and reply generator
// depends on s5hp_pkg
`default_nettype none

module s5hp_queue #(
    parameter int DEPTH = s5hp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire s5hp_pkg::action_t  push_data,
    output logic                    not_full,
    input  wire logic               pop,
    output logic                    not_empty,
    output s5hp_pkg::action_t       head
);
    import s5hp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    action_t            mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push, do_pop;

    assign not_full  = (count_reg != CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign head      = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/s5hp_back.sv =====
// s5hp_back: expands queued actions into result items, one per cycle while an action is queued and m_ready allows
// depends on s5hp_pkg
`default_nettype none

module s5hp_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              head_valid,
    input  wire s5hp_pkg::action_t head,
    output logic                   pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output s5hp_pkg::out_item_t    m_item
);
    import s5hp_pkg::*;

    logic [IDX_W-1:0] idx_reg;
    logic             m_valid_reg;
    out_item_t        m_item_reg;
    out_item_t        item;
    logic             load;

    assign load    = head_valid && (!m_valid_reg || m_ready);
    assign pop     = load && item.last;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // build the item at the current byte index of the head action
    always_comb begin
        item.kind        = KIND_REPLY;
        item.value       = 8'd0;
        item.addr_type   = AT_IPV4;
        item.dest_port   = 16'd0;
        item.close_after = 1'b0;
        item.last        = 1'b1;
        case (head.op)
            ACT_FAIL: begin
                item.close_after = 1'b1;
                item.last        = (idx_reg == IDX_W'(FAIL_LEN - 1));
                case (idx_reg)
                    IDX_W'(0): item.value = SOCKS_VER;
                    IDX_W'(1): item.value = head.data;
                    IDX_W'(3): item.value = ATYP_IPV4;
                    default:   item.value = 8'd0;
                endcase
            end
            ACT_HELLO_OK: begin
                item.value = (idx_reg == '0) ? SOCKS_VER : METHOD_NOAUTH;
                item.last  = (idx_reg != '0);
            end
            ACT_HELLO_REJ: begin
                item.value       = (idx_reg == '0) ? SOCKS_VER : METHOD_NONE;
                item.last        = (idx_reg != '0);
                item.close_after = 1'b1;
            end
            ACT_ADDR: begin
                item.kind      = KIND_ADDR;
                item.value     = head.data;
                item.addr_type = head.addr_type;
            end
            ACT_DONE: begin
                item.kind      = KIND_DONE;
                item.addr_type = head.addr_type;
                item.dest_port = head.dest_port;
            end
            default: begin
                item.last = 1'b1;
            end
        endcase
    end

    // byte index and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                idx_reg     <= item.last ? '0 : idx_reg + 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_item_reg <= item;
        end
    end

endmodule

`default_nettype wire

// ===== design/socks5_handshake_parser.sv =====
// socks5_handshake_parser: server side socks5 greeting and request parser
// an accepted byte's action is written into the action queue and then loaded into the
// s5hp_back output register; throughput: one input byte per cycle while the queue is not
// full; results leave at one per cycle while m_ready allows; an error reply holds the queue
// head for its ten bytes and stalls input once QUEUE_DEPTH fill
// reset: aresetn synchronous active low, returns to awaiting a greeting
`default_nettype none

module socks5_handshake_parser #(
    parameter int QUEUE_DEPTH = s5hp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire s5hp_pkg::in_item_t s_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output s5hp_pkg::out_item_t     m_item
);
    import s5hp_pkg::*;

    action_t act, head;
    logic    act_valid, q_not_full, q_not_empty, pop;

    // parser
    s5hp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .act_ready (q_not_full),
        .act_valid (act_valid),
        .act       (act)
    );

    // action queue
    s5hp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (act_valid),
        .push_data (act),
        .not_full  (q_not_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head      (head)
    );

    // reply generator
    s5hp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_not_empty),
        .head       (head),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// testbench: self-checking regression for socks5_handshake_parser
// feeds client words over valid/ready; checks every result word vs the local model or pinned rows
// depends on s5hp_pkg and the socks5_handshake_parser rtl

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import s5hp_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 4;
    localparam int RANDOM_WORDS = 330;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 20;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HELLO_LEN    = 2;

    // command value the block has no use for
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam logic [7:0] NO_FAULT  = 8'h00;

    // session progress as seen by the model
    typedef enum logic [3:0] {
        P_HELLO_VER, P_HELLO_NM, P_METHODS, P_REQ_VER, P_REQ_CMD, P_REQ_RSV,
        P_REQ_ATYP, P_DOM_LEN, P_ADDR, P_PORT_HI, P_PORT_LO, P_CLOSED
    } sess_phase_t;

    // results pinned by hand on a directed row
    typedef enum logic [2:0] {
        PIN_NONE, PIN_SILENT, PIN_FAIL, PIN_HELLO_OK, PIN_HELLO_REJ
    } pin_t;

    typedef struct packed {
        pin_t       pin;
        logic [7:0] code;
        in_item_t   word;
    } row_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    socks5_handshake_parser dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // directed walk: greeting faults, closed session, both hello replies, requests
    row_t directed_rows [29] = '{
        '{PIN_SILENT,    NO_FAULT,       '{CMD_BYTE,  SOCKS_VER}},
        '{PIN_FAIL,      REP_GENERAL,    '{CMD_BYTE,  8'h00}},
        '{PIN_SILENT,    NO_FAULT,       '{CMD_NEW,   8'hFF}},
        '{PIN_SILENT,    NO_FAULT,       '{CMD_BYTE,  8'hFA}},
        '{PIN_FAIL,      REP_GENERAL,    '{CMD_BYTE,  8'h01}},
        '{PIN_SILENT,    NO_FAULT,       '{CMD_BYTE,  SOCKS_VER}},
        '{PIN_SILENT,    NO_FAULT,       '{CMD_CLOSE, 8'h00}},
        '{PIN_SILENT,    NO_FAULT,       '{CMD_SPARE, 8'hAA}},
        '{PIN_SILENT,    NO_FAULT,       '{CMD_NEW,   8'h00}},
        '{PIN_SILENT,    NO_FAULT,       '{CMD_BYTE,  SOCKS_VER}},
        '{PIN_SILENT,    NO_FAULT,       '{CMD_BYTE,  8'h01}},
        '{PIN_HELLO_REJ, NO_FAULT,       '{CMD_BYTE,  8'hFF}},
        '{PIN_SILENT,    NO_FAULT,       '{CMD_NEW,   8'h55}},
        '{PIN_SILENT,    NO_FAULT,       '{CMD_BYTE,  SOCKS_VER}},
        '{PIN_SILENT,    NO_FAULT,       '{CMD_BYTE,  8'h02}},
        '{PIN_SILENT,    NO_FAULT,       '{CMD_BYTE,  8'hFF}},
        '{PIN_HELLO_OK,  NO_FAULT,       '{CMD_BYTE,  METHOD_NOAUTH}},
        '{PIN_NONE,      NO_FAULT,       '{CMD_BYTE,  SOCKS_VER}},
        '{PIN_NONE,      NO_FAULT,       '{CMD_BYTE,  REQ_CONNECT}},
        '{PIN_NONE,      NO_FAULT,       '{CMD_BYTE,  REQ_RSV}},
        '{PIN_NONE,      NO_FAULT,       '{CMD_BYTE,  ATYP_DOMAIN}},
        '{PIN_NONE,      NO_FAULT,       '{CMD_BYTE,  8'h00}},
        '{PIN_NONE,      NO_FAULT,       '{CMD_BYTE,  8'hFF}},
        '{PIN_NONE,      NO_FAULT,       '{CMD_BYTE,  8'hFF}},
        '{PIN_NONE,      NO_FAULT,       '{CMD_BYTE,  SOCKS_VER}},
        '{PIN_NONE,      NO_FAULT,       '{CMD_BYTE,  8'h02}},
        '{PIN_NONE,      NO_FAULT,       '{CMD_BYTE,  8'h01}},
        '{PIN_FAIL,      REP_CMD_UNSUP,  '{CMD_BYTE,  8'h09}},
        '{PIN_SILENT,    NO_FAULT,       '{CMD_NEW,   8'h00}}
    };

    row_t        stim_rows [$];
    out_item_t   step_words [$];
    out_item_t   owed_words [$];
    bit          stim_done  = 1'b0;
    int          mismatches = 0;
    int          cycle_count = 0;

    // model state
    sess_phase_t sess_phase;
    bit          hello_ver_ok;
    logic [7:0]  methods_left;
    bit          noauth_seen;
    logic [7:0]  hdr_fault;
    logic [1:0]  addr_kind;
    logic [7:0]  addr_left;
    logic [7:0]  port_hi;

    function automatic void clear_session();
        sess_phase   = P_HELLO_VER;
        hello_ver_ok = 1'b0;
        methods_left = '0;
        noauth_seen  = 1'b0;
        hdr_fault    = NO_FAULT;
        addr_kind    = AT_IPV4;
        addr_left    = '0;
        port_hi      = '0;
    endfunction

    // server reply 05 <second> ..., ten bytes with bound ipv4 for an error reply
    function automatic void push_reply(input logic [7:0] second, input int len,
                                       input bit closes);
        out_item_t o;
        int i;
        for (i = 0; i < len; i++) begin
            o = '0;
            o.kind = KIND_REPLY;
            o.close_after = closes;
            case (i)
                0: o.value = SOCKS_VER;
                1: o.value = second;
                3: o.value = ATYP_IPV4;
                default: o.value = 8'h00;
            endcase
            step_words.push_back(o);
        end
    endfunction

    function automatic void fail_session(input logic [7:0] code);
        push_reply(code, FAIL_LEN, 1'b1);
        sess_phase = P_CLOSED;
    endfunction

    // advance the model by one client word, leaving its results in step_words
    function automatic void parse_client_word(input in_item_t w);
        out_item_t o;
        logic [7:0] b;
        b = w.rx_byte;
        step_words.delete();
        case (w.cmd)
            CMD_NEW: clear_session();
            CMD_CLOSE: if (sess_phase != P_CLOSED) fail_session(REP_GENERAL);
            CMD_BYTE: begin
                case (sess_phase)
                    P_HELLO_VER: begin
                        hello_ver_ok = (b == SOCKS_VER);
                        sess_phase = P_HELLO_NM;
                    end
                    P_HELLO_NM: begin
                        if (!hello_ver_ok || b == 8'h00) begin
                            fail_session(REP_GENERAL);
                        end else begin
                            methods_left = b;
                            noauth_seen = 1'b0;
                            sess_phase = P_METHODS;
                        end
                    end
                    P_METHODS: begin
                        if (b == METHOD_NOAUTH) noauth_seen = 1'b1;
                        methods_left = methods_left - 8'd1;
                        if (methods_left == 8'd0) begin
                            if (noauth_seen) begin
                                push_reply(METHOD_NOAUTH, HELLO_LEN, 1'b0);
                                sess_phase = P_REQ_VER;
                            end else begin
                                push_reply(METHOD_NONE, HELLO_LEN, 1'b1);
                                sess_phase = P_CLOSED;
                            end
                        end
                    end
                    P_REQ_VER: begin
                        hdr_fault = (b != SOCKS_VER) ? REP_GENERAL : NO_FAULT;
                        sess_phase = P_REQ_CMD;
                    end
                    P_REQ_CMD: begin
                        if (hdr_fault == NO_FAULT && b != REQ_CONNECT) hdr_fault = REP_CMD_UNSUP;
                        sess_phase = P_REQ_RSV;
                    end
                    P_REQ_RSV: begin
                        if (hdr_fault == NO_FAULT && b != REQ_RSV) hdr_fault = REP_GENERAL;
                        sess_phase = P_REQ_ATYP;
                    end
                    P_REQ_ATYP: begin
                        if (hdr_fault != NO_FAULT) begin
                            fail_session(hdr_fault);
                        end else begin
                            case (b)
                                ATYP_IPV4: begin
                                    addr_kind = AT_IPV4;
                                    addr_left = IPV4_LEN;
                                    sess_phase = P_ADDR;
                                end
                                ATYP_IPV6: begin
                                    addr_kind = AT_IPV6;
                                    addr_left = IPV6_LEN;
                                    sess_phase = P_ADDR;
                                end
                                ATYP_DOMAIN: begin
                                    addr_kind = AT_DOMAIN;
                                    sess_phase = P_DOM_LEN;
                                end
                                default: fail_session(REP_ATYP_UNSUP);
                            endcase
                        end
                    end
                    // length byte itself is not passed on
                    P_DOM_LEN: begin
                        addr_left = b;
                        sess_phase = (b == 8'h00) ? P_PORT_HI : P_ADDR;
                    end
                    P_ADDR: begin
                        o = '0;
                        o.kind = KIND_ADDR;
                        o.value = b;
                        o.addr_type = addr_kind;
                        step_words.push_back(o);
                        addr_left = addr_left - 8'd1;
                        if (addr_left == 8'd0) sess_phase = P_PORT_HI;
                    end
                    P_PORT_HI: begin
                        port_hi = b;
                        sess_phase = P_PORT_LO;
                    end
                    P_PORT_LO: begin
                        o = '0;
                        o.kind = KIND_DONE;
                        o.addr_type = addr_kind;
                        o.dest_port = {port_hi, b};
                        step_words.push_back(o);
                        sess_phase = P_REQ_VER;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    endfunction

    // random stimulus builders
    function automatic void put_word(input logic [1:0] cmd, input logic [7:0] b);
        row_t r;
        r.pin = PIN_NONE;
        r.code = NO_FAULT;
        r.word.cmd = cmd;
        r.word.rx_byte = b;
        stim_rows.push_back(r);
    endfunction

    // a client byte, now and then preceded by a peer close or an unused command
    function automatic void put_byte(input logic [7:0] b);
        int r;
        r = $urandom_range(0, 99);
        if (r == 0) put_word(CMD_CLOSE, 8'($urandom));
        else if (r < 3) put_word(CMD_SPARE, 8'($urandom));
        put_word(CMD_BYTE, b);
    endfunction

    function automatic void gen_request();
        logic [7:0] atyp;
        int len;
        int r;
        int d;
        put_byte(($urandom_range(0, 11) == 0) ? 8'($urandom) : SOCKS_VER);
        put_byte(($urandom_range(0, 11) == 0) ? 8'($urandom) : REQ_CONNECT);
        put_byte(($urandom_range(0, 11) == 0) ? 8'($urandom) : REQ_RSV);
        r = $urandom_range(0, 11);
        if (r < 4) begin
            atyp = ATYP_IPV4;
            len = int'(IPV4_LEN);
        end else if (r < 7) begin
            atyp = ATYP_DOMAIN;
            d = $urandom_range(0, 39);
            len = (d < 6) ? 0 : (d == 39) ? 255 : $urandom_range(1, 12);
        end else if (r < 10) begin
            atyp = ATYP_IPV6;
            len = int'(IPV6_LEN);
        end else begin
            atyp = 8'($urandom);
            len = 0;
        end
        put_byte(atyp);
        if (atyp == ATYP_DOMAIN) put_byte(8'(len));
        repeat (len) put_byte(8'($urandom));
        put_byte(8'($urandom));
        put_byte(8'($urandom));
    endfunction

    // new connection, greeting, a few requests, sometimes a close and trailing noise
    function automatic void gen_session();
        int nm;
        int pos;
        int r;
        int i;
        put_word(CMD_NEW, 8'($urandom));
        put_byte(($urandom_range(0, 15) == 0) ? 8'($urandom) : SOCKS_VER);
        r = $urandom_range(0, 49);
        nm = (r == 0) ? 0 : (r == 1) ? 255 : (r < 6) ? $urandom_range(5, 32)
                                                   : $urandom_range(1, 4);
        put_byte(8'(nm));
        pos = -1;
        if (nm > 0 && $urandom_range(0, 4) != 0) pos = $urandom_range(0, nm - 1);
        for (i = 0; i < nm; i++) begin
            put_byte((i == pos) ? METHOD_NOAUTH : 8'($urandom_range(1, 255)));
        end
        repeat ($urandom_range(1, 3)) gen_request();
        if ($urandom_range(0, 3) == 0) put_word(CMD_CLOSE, 8'($urandom));
        repeat ($urandom_range(0, 2)) put_byte(8'($urandom));
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_word(input out_item_t got);
        out_item_t want;
        if (owed_words.size() == 0) begin
            $error("result word with none owed: kind %0d value 0x%02h", got.kind, got.value);
            mismatches++;
        end else begin
            want = owed_words.pop_front();
            check_field("kind", 16'(want.kind), 16'(got.kind));
            check_field("value", 16'(want.value), 16'(got.value));
            check_field("addr_type", 16'(want.addr_type), 16'(got.addr_type));
            check_field("dest_port", want.dest_port, got.dest_port);
            check_field("close_after", 16'(want.close_after), 16'(got.close_after));
            check_field("last", 16'(want.last), 16'(got.last));
        end
    endfunction

    // input side: walk directed rows then random sessions, predict on acceptance
    initial begin : word_source
        row_t row;
        int gap;
        bit calm;
        calm = 1'b0;
        clear_session();
        foreach (directed_rows[i]) stim_rows.push_back(directed_rows[i]);
        while (stim_rows.size() < $size(directed_rows) + RANDOM_WORDS) gen_session();
        while (!aresetn) @(posedge aclk);
        while (stim_rows.size() > 0) begin
            row = stim_rows.pop_front();
            if ($urandom_range(0, 19) == 0) calm = !calm;
            gap = calm ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_valid <= 1'b1;
            s_item <= row.word;
            do @(posedge aclk); while (!s_ready);
            parse_client_word(row.word);
            // hand-pinned rows replace what the model produced
            if (row.pin != PIN_NONE) begin
                step_words.delete();
                case (row.pin)
                    PIN_FAIL: push_reply(row.code, FAIL_LEN, 1'b1);
                    PIN_HELLO_OK: push_reply(METHOD_NOAUTH, HELLO_LEN, 1'b0);
                    PIN_HELLO_REJ: push_reply(METHOD_NONE, HELLO_LEN, 1'b1);
                    default: ;
                endcase
            end
            if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
            foreach (step_words[k]) owed_words.push_back(step_words[k]);
        end
        s_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // result side: random stalls, two long hold-offs to back up the block
    initial begin : word_sink
        int stall;
        int taken;
        bit calm;
        calm = 1'b0;
        taken = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 19) == 0) calm = !calm;
            stall = calm ? 0 : $urandom_range(0, 7);
            if (taken == 40 || taken == 250) stall = HOLD_CYCLES;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            check_word(m_item);
            taken++;
        end
    end

    // reset, then wait for all words to drain
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        while (!stim_done || owed_words.size() > 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("socks5_handshake_parser regression: pass");
        end else begin
            $display("socks5_handshake_parser regression: fail");
        end
        $finish;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("socks5_handshake_parser regression: fail");
            $finish;
        end
    end

endmodule

// ===== files.f =====
design/s5hp_pkg.sv
design/s5hp_front.sv
design/s5hp_queue.sv
design/s5hp_back.sv
design/socks5_handshake_parser.sv
verif/testbench.sv
